FILE: design/rbhi_pkg.sv
// Shared types, codes and sizes for the row-band binned hit index.
package rbhi_pkg;

    localparam int MAX_RECTS_DEF = 1024;
    localparam int NUM_BANDS_DEF = 64;
    localparam int EPB_DEF       = 64;

    localparam int COORD_W   = 24;
    localparam int BH_W      = 12;
    localparam int SCROLL_W  = 23;
    localparam int IDX_OUT_W = 10;
    // Widest nonnegative value that is divided by the band height.
    localparam int DVD_W     = 25;

    localparam logic [BH_W-1:0] BH_RESET = 12'd64;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_BAND_ERR   = 2'd2;

    localparam logic [1:0] CFG_BAND_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_X    = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_Y    = 2'd2;
    localparam logic [1:0] CFG_SCROLL      = 2'd3;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic signed [COORD_W-1:0] rect_w;
        logic signed [COORD_W-1:0] rect_h;
        logic                      spans_height;
        logic                      is_fixed;
        logic                      is_link;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        logic                 hit;
        logic [IDX_OUT_W-1:0] rect_index;
    } t_resp;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] width;
        logic signed [COORD_W-1:0] height;
        logic                      link;
    } t_rect;

endpackage

FILE: design/rbhi_div.sv
// Bit-serial restoring divider that maps a coordinate to its band number.
module rbhi_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rbhi_pkg::DVD_W-1:0]   i_dividend,
    input  logic [rbhi_pkg::BH_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [rbhi_pkg::DVD_W-1:0]   o_quotient
);
    import rbhi_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [BH_W-1:0]  r_rem;
    logic [BH_W-1:0]  r_div;
    logic [DVD_W-1:0] r_q;
    logic [BH_W:0]    trial;
    logic [BH_W:0]    diff;
    logic             fits;

    // One quotient bit per cycle; the dividend shifts out as the quotient shifts in.
    assign trial = {r_rem, r_q[DVD_W-1]};
    assign fits  = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[BH_W-1:0] : trial[BH_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: design/row_band_binned_hit_index.sv
// Top level of the row-band binned hit index: sequencer, stores and register port.
//
// One request is worked at a time and always yields exactly one result transfer.
// Every request passes through dispatch and the result stage. A clear, an unknown
// request, an insert into a full table or of a fixed rectangle, and a query that
// misses before any band is looked at go straight from dispatch to the result
// stage. A binned insert runs the shared serial divider once or twice, then walks
// its bands and appends to each in turn; the walk stops at the end of its range,
// at a band past the last one or at a full band list. Where the walk opens bands
// for the first time since the last clear, each opened band is first set empty.
// A query that reaches the scan runs the divider once, then scans the band above,
// its own band and the band below one entry at a time, skipping bands not yet
// opened (3*ENTRIES_PER_BAND entries at most), and stops at the first hit.
// The divider and the one-entry-at-a-time scan of the band store set the rate.
// The next request is taken while a result still waits at the output.
module row_band_binned_hit_index #(
    parameter int MAX_RECTS        = rbhi_pkg::MAX_RECTS_DEF,
    parameter int NUM_BANDS        = rbhi_pkg::NUM_BANDS_DEF,
    parameter int ENTRIES_PER_BAND = rbhi_pkg::EPB_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rbhi_pkg::t_req                 i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rbhi_pkg::t_resp                o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [rbhi_pkg::COORD_W-1:0]   i_cfg_data
);
    import rbhi_pkg::*;

    localparam int IDX_W  = $clog2(MAX_RECTS);
    localparam int CNT_W  = $clog2(MAX_RECTS + 1);
    localparam int BAND_W = $clog2(NUM_BANDS);
    localparam int USED_W = $clog2(NUM_BANDS + 1);
    localparam int SLOT_W = $clog2(ENTRIES_PER_BAND);
    localparam int FILL_W = $clog2(ENTRIES_PER_BAND + 1);
    localparam int QW     = DVD_W;
    localparam int C_W    = 27;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_IDIV0    = 4'd2;
    localparam logic [3:0] S_IDIV1    = 4'd3;
    localparam logic [3:0] S_BAND     = 4'd4;
    localparam logic [3:0] S_GROW     = 4'd5;
    localparam logic [3:0] S_FILLCK   = 4'd6;
    localparam logic [3:0] S_QDIV     = 4'd7;
    localparam logic [3:0] S_QBAND    = 4'd8;
    localparam logic [3:0] S_QENT     = 4'd9;
    localparam logic [3:0] S_QRECT    = 4'd10;
    localparam logic [3:0] S_QX       = 4'd11;
    localparam logic [3:0] S_QY       = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    // Configuration registers.
    logic [BH_W-1:0]            r_band_h;
    logic signed [COORD_W-1:0]  r_org_x;
    logic signed [COORD_W-1:0]  r_org_y;
    logic [SCROLL_W-1:0]        r_scroll;

    // Control state.
    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [USED_W-1:0] r_used, n_used;
    logic              r_ovalid;

    // Working registers of the current request.
    t_req                r_in;
    t_resp               r_res, n_res;
    t_resp               r_out;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [23:0]         r_y1m1, n_y1m1;
    logic                r_y1pos, n_y1pos;
    logic [QW-1:0]       r_t, n_t;
    logic [QW-1:0]       r_t1, n_t1;
    logic [QW-1:0]       r_tc, n_tc;
    logic [1:0]          r_off, n_off;
    logic [BAND_W-1:0]   r_qband, n_qband;
    logic [FILL_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]    r_k, n_k;
    logic signed [24:0]  r_dx, n_dx;
    logic signed [25:0]  r_dy, n_dy;

    // Stores.
    t_rect             r_rect_mem [0:MAX_RECTS-1];
    logic [IDX_W-1:0]  r_ent_mem  [0:NUM_BANDS-1][0:ENTRIES_PER_BAND-1];
    logic [FILL_W-1:0] r_fill_mem [0:NUM_BANDS-1];
    t_rect             r_rect_q;
    logic [IDX_W-1:0]  r_ent_q;
    logic [FILL_W-1:0] r_fill_q;

    logic              rect_we, rect_re;
    logic [IDX_W-1:0]  rect_addr;
    t_rect             rect_wd;
    logic              ent_we, ent_re;
    logic [BAND_W-1:0] ent_band;
    logic [SLOT_W-1:0] ent_slot;
    logic              fill_we, fill_re;
    logic [BAND_W-1:0] fill_wa, fill_ra;
    logic [FILL_W-1:0] fill_wd;

    // Divider hookup.
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [BH_W-1:0]  eff_bh;
    logic             div_done;
    logic [DVD_W-1:0] div_q;

    // Combinational helpers.
    logic                  in_xfer;
    logic                  out_load;
    logic signed [24:0]    ins_sum;
    logic signed [24:0]    ins_y1s;
    logic [22:0]           ins_y0;
    logic [23:0]           ins_y1;
    logic signed [24:0]    q_dx;
    logic signed [25:0]    q_dy;
    logic [QW:0]           q_t;
    logic signed [C_W-1:0] c_x0, c_xe, c_dx, c_y0, c_ye, c_dy;
    logic [IDX_W+IDX_OUT_W-1:0] idx_ext_c, idx_ext_k;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_ovalid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign eff_bh = (r_band_h == '0) ? BH_W'(1) : r_band_h;

    rbhi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (eff_bh),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Band range of an insert: the end row is clamped up to the clamped top.
    always_comb begin
        ins_sum = 25'(r_in.rect_y) + 25'(r_in.rect_h);
        ins_y0  = r_in.rect_y[23] ? 23'd0 : r_in.rect_y[22:0];
        ins_y1s = r_in.spans_height ? ins_sum : 25'(r_in.rect_y);
        if (ins_y1s < $signed({2'b00, ins_y0})) begin
            ins_y1 = {1'b0, ins_y0};
        end else begin
            ins_y1 = ins_y1s[23:0];
        end
    end

    assign q_dx = 25'(r_in.point_x) - 25'(r_org_x);
    assign q_dy = 26'(r_in.point_y) - 26'(r_org_y) + 26'($signed({1'b0, r_scroll}));
    assign q_t  = {1'b0, r_tc} + (QW+1)'(r_off) - (QW+1)'(1);

    assign c_x0 = C_W'(r_rect_q.left);
    assign c_xe = c_x0 + C_W'(r_rect_q.width);
    assign c_dx = C_W'(r_dx);
    assign c_y0 = C_W'(r_rect_q.top);
    assign c_ye = c_y0 + C_W'(r_rect_q.height);
    assign c_dy = C_W'(r_dy);

    assign idx_ext_c = {{IDX_OUT_W{1'b0}}, r_count[IDX_W-1:0]};
    assign idx_ext_k = {{IDX_OUT_W{1'b0}}, r_k};

    always_comb begin
        rect_wd.left   = r_in.rect_x;
        rect_wd.top    = r_in.rect_y;
        rect_wd.width  = r_in.rect_w;
        rect_wd.height = r_in.rect_h;
        rect_wd.link   = r_in.is_link;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_used    = r_used;
        n_res     = r_res;
        n_idx     = r_idx;
        n_y1m1    = r_y1m1;
        n_y1pos   = r_y1pos;
        n_t       = r_t;
        n_t1      = r_t1;
        n_tc      = r_tc;
        n_off     = r_off;
        n_qband   = r_qband;
        n_i       = r_i;
        n_k       = r_k;
        n_dx      = r_dx;
        n_dy      = r_dy;
        div_start = 1'b0;
        div_dvd   = '0;
        rect_we   = 1'b0;
        rect_re   = 1'b0;
        rect_addr = '0;
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        ent_band  = '0;
        ent_slot  = '0;
        fill_we   = 1'b0;
        fill_re   = 1'b0;
        fill_wa   = '0;
        fill_wd   = '0;
        fill_ra   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res   = '0;
                n_state = S_DONE;
                unique case (r_in.req_type)
                    REQ_INSERT: begin
                        if (r_count >= CNT_W'(MAX_RECTS)) begin
                            n_res.status = ST_TABLE_FULL;
                        end else begin
                            rect_we          = 1'b1;
                            rect_addr        = r_count[IDX_W-1:0];
                            n_idx            = r_count[IDX_W-1:0];
                            n_count          = r_count + 1'b1;
                            n_res.rect_index = idx_ext_c[IDX_OUT_W-1:0];
                            n_y1m1           = ins_y1 - 24'd1;
                            n_y1pos          = (ins_y1 != 24'd0);
                            if (!r_in.is_fixed) begin
                                div_start = 1'b1;
                                div_dvd   = DVD_W'(ins_y0);
                                n_state   = S_IDIV0;
                            end
                        end
                    end
                    REQ_QUERY: begin
                        n_dx = q_dx;
                        n_dy = q_dy;
                        if (r_count != '0 && r_used != '0 && q_dx >= 0 && q_dy >= 0) begin
                            div_start = 1'b1;
                            div_dvd   = q_dy[DVD_W-1:0];
                            n_state   = S_QDIV;
                        end
                    end
                    REQ_CLEAR: begin
                        n_count = '0;
                        n_used  = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_IDIV0: begin
                if (div_done) begin
                    n_t = div_q;
                    if (r_y1pos) begin
                        div_start = 1'b1;
                        div_dvd   = DVD_W'(r_y1m1);
                        n_state   = S_IDIV1;
                    end else begin
                        n_t1    = div_q;
                        n_state = S_BAND;
                    end
                end
            end
            S_IDIV1: begin
                if (div_done) begin
                    n_t1    = div_q;
                    n_state = S_BAND;
                end
            end
            S_BAND: begin
                if (r_t > r_t1) begin
                    n_state = S_DONE;
                end else if (r_t >= QW'(NUM_BANDS)) begin
                    n_res.status = ST_BAND_ERR;
                    n_state      = S_DONE;
                end else if (r_t >= QW'(r_used)) begin
                    n_state = S_GROW;
                end else begin
                    fill_re = 1'b1;
                    fill_ra = r_t[BAND_W-1:0];
                    n_state = S_FILLCK;
                end
            end
            S_GROW: begin
                // Bands opened for the first time since a clear start out empty.
                fill_we = 1'b1;
                fill_wa = r_used[BAND_W-1:0];
                fill_wd = '0;
                n_used  = r_used + 1'b1;
                if (QW'(r_used) == r_t) begin
                    n_state = S_BAND;
                end
            end
            S_FILLCK: begin
                if (r_fill_q >= FILL_W'(ENTRIES_PER_BAND)) begin
                    n_res.status = ST_BAND_ERR;
                    n_state      = S_DONE;
                end else begin
                    fill_we  = 1'b1;
                    fill_wa  = r_t[BAND_W-1:0];
                    fill_wd  = r_fill_q + 1'b1;
                    ent_we   = 1'b1;
                    ent_band = r_t[BAND_W-1:0];
                    ent_slot = r_fill_q[SLOT_W-1:0];
                    n_t      = r_t + 1'b1;
                    n_state  = S_BAND;
                end
            end
            S_QDIV: begin
                if (div_done) begin
                    n_tc    = div_q;
                    n_off   = 2'd0;
                    n_state = S_QBAND;
                end
            end
            S_QBAND: begin
                // Offsets 0, 1 and 2 stand for the band above, the band itself and below.
                if (r_off == 2'd3) begin
                    n_state = S_DONE;
                end else if ((r_off == 2'd0 && r_tc == '0) ||
                             q_t >= (QW+1)'(r_used)) begin
                    n_off = r_off + 1'b1;
                end else begin
                    fill_re = 1'b1;
                    fill_ra = q_t[BAND_W-1:0];
                    n_qband = q_t[BAND_W-1:0];
                    n_i     = '0;
                    n_state = S_QENT;
                end
            end
            S_QENT: begin
                if (r_i >= r_fill_q) begin
                    n_off   = r_off + 1'b1;
                    n_state = S_QBAND;
                end else begin
                    ent_re   = 1'b1;
                    ent_band = r_qband;
                    ent_slot = r_i[SLOT_W-1:0];
                    n_state  = S_QRECT;
                end
            end
            S_QRECT: begin
                n_k = r_ent_q;
                if (CNT_W'(r_ent_q) >= r_count) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_QENT;
                end else begin
                    rect_re   = 1'b1;
                    rect_addr = r_ent_q;
                    n_state   = S_QX;
                end
            end
            S_QX: begin
                if (r_rect_q.link && r_rect_q.width > 0 && r_rect_q.height > 0 &&
                    c_dx >= c_x0 && c_dx < c_xe) begin
                    n_state = S_QY;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_QENT;
                end
            end
            S_QY: begin
                if (c_dy >= c_y0 && c_dy < c_ye) begin
                    n_res.hit        = 1'b1;
                    n_res.rect_index = idx_ext_k[IDX_OUT_W-1:0];
                    n_state          = S_DONE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_QENT;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            r_band_h <= BH_RESET;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_scroll <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_used  <= n_used;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BAND_HEIGHT: r_band_h <= i_cfg_data[BH_W-1:0];
                    CFG_ORIGIN_X:    r_org_x  <= i_cfg_data;
                    CFG_ORIGIN_Y:    r_org_y  <= i_cfg_data;
                    CFG_SCROLL:      r_scroll <= i_cfg_data[SCROLL_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in;
        end
        if (out_load) begin
            r_out <= r_res;
        end
        r_res   <= n_res;
        r_idx   <= n_idx;
        r_y1m1  <= n_y1m1;
        r_y1pos <= n_y1pos;
        r_t     <= n_t;
        r_t1    <= n_t1;
        r_tc    <= n_tc;
        r_off   <= n_off;
        r_qband <= n_qband;
        r_i     <= n_i;
        r_k     <= n_k;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
    end

    always_ff @(posedge i_clk) begin
        if (rect_we) begin
            r_rect_mem[rect_addr] <= rect_wd;
        end
        if (rect_re) begin
            r_rect_q <= r_rect_mem[rect_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_band][ent_slot] <= r_idx;
        end
        if (ent_re) begin
            r_ent_q <= r_ent_mem[ent_band][ent_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_fill_mem[fill_wa] <= fill_wd;
        end
        if (fill_re) begin
            r_fill_q <= r_fill_mem[fill_ra];
        end
    end

endmodule

FILE: tb/row_band_binned_hit_index_test.sv
// Self-checking testbench for the row-band binned hit index.
module row_band_binned_hit_index_test;
    import rbhi_pkg::*;

    localparam int MAX_RECTS = MAX_RECTS_DEF;
    localparam int NUM_BANDS = NUM_BANDS_DEF;
    localparam int EPB       = EPB_DEF;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        t_req  req;
        logic  given;
        t_resp want;
    } t_dir_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_req        i_in        = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_BAND_HEIGHT;
    logic [23:0] i_cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_resp       o_out;
    logic        o_cfg_ready;

    // Register copies and index contents as the block should hold them.
    logic [BH_W-1:0]     cur_band_h;
    longint              cur_org_x;
    longint              cur_org_y;
    logic [SCROLL_W-1:0] cur_scroll;
    t_rect               rect_tab [MAX_RECTS];
    int unsigned         rect_total;
    int unsigned         band_tab [NUM_BANDS][EPB];
    int                  band_len [NUM_BANDS];
    int                  open_bands;

    t_resp pending_resp [$];
    int    fail_cnt      = 0;
    int    n_accepted    = 0;
    int    full_seen     = 0;
    bit    squeeze_done  = 1'b0;

    // Mix of the current random phase.
    int ph_ins_pct;
    int ph_clr_pct;
    int ph_fix_pct;
    int ph_span;
    bit ph_steady;

    always #2 i_clk = ~i_clk;

    row_band_binned_hit_index u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic longint sx24(input logic [23:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [23:0] c24(input longint v);
        return v[23:0];
    endfunction

    function automatic int eff_band_h();
        return (cur_band_h == 0) ? 1 : int'(cur_band_h);
    endfunction

    function automatic void index_clear();
        rect_total = 0;
        open_bands = 0;
        foreach (band_len[b]) band_len[b] = 0;
    endfunction

    function automatic void reg_apply(input logic [1:0] idx, input logic [23:0] d);
        case (idx)
            CFG_BAND_HEIGHT: cur_band_h = d[BH_W-1:0];
            CFG_ORIGIN_X:    cur_org_x  = sx24(d);
            CFG_ORIGIN_Y:    cur_org_y  = sx24(d);
            CFG_SCROLL:      cur_scroll = d[SCROLL_W-1:0];
        endcase
    endfunction

    // Applies one request to the index copy and returns the result it must give.
    function automatic t_resp index_apply(input t_req r);
        t_resp       res;
        longint      bh, y, y0, y1, t, t_lo, t_hi, dx, dy, tc, x0, ty;
        int unsigned k;
        int          i;
        bit          found;
        res = '0;
        bh  = eff_band_h();
        case (r.req_type)
            REQ_INSERT: begin
                if (rect_total >= MAX_RECTS) begin
                    res.status = ST_TABLE_FULL;
                end else begin
                    k = rect_total;
                    rect_total++;
                    res.rect_index       = k[IDX_OUT_W-1:0];
                    rect_tab[k].left   = r.rect_x;
                    rect_tab[k].top    = r.rect_y;
                    rect_tab[k].width  = r.rect_w;
                    rect_tab[k].height = r.rect_h;
                    rect_tab[k].link   = r.is_link;
                    if (!r.is_fixed) begin
                        y  = sx24(r.rect_y);
                        y0 = (y < 0) ? 0 : y;
                        y1 = r.spans_height ? y + sx24(r.rect_h) : y;
                        if (y1 < y0) y1 = y0;
                        t_lo = y0 / bh;
                        t_hi = (y1 > 0) ? (y1 - 1) / bh : t_lo;
                        for (t = t_lo; t <= t_hi; t++) begin
                            if (t >= NUM_BANDS) begin
                                res.status = ST_BAND_ERR;
                                break;
                            end
                            // A band that is reached counts as used even when it is full.
                            if (t + 1 > open_bands) open_bands = int'(t + 1);
                            if (band_len[t] >= EPB) begin
                                res.status = ST_BAND_ERR;
                                break;
                            end
                            band_tab[t][band_len[t]] = k;
                            band_len[t]++;
                        end
                    end
                end
            end
            REQ_QUERY: begin
                dx = sx24(r.point_x) - cur_org_x;
                dy = sx24(r.point_y) - cur_org_y + longint'(cur_scroll);
                if (rect_total != 0 && open_bands != 0 && dx >= 0 && dy >= 0) begin
                    tc    = dy / bh;
                    found = 1'b0;
                    for (t = tc - 1; t <= tc + 1 && !found; t++) begin
                        if (t < 0 || t >= open_bands || t >= NUM_BANDS) continue;
                        for (i = 0; i < band_len[t] && !found; i++) begin
                            k = band_tab[t][i];
                            if (k >= rect_total || !rect_tab[k].link) continue;
                            if (sx24(rect_tab[k].width) <= 0 || sx24(rect_tab[k].height) <= 0)
                                continue;
                            x0 = sx24(rect_tab[k].left);
                            ty = sx24(rect_tab[k].top);
                            if (dx >= x0 && dx < x0 + sx24(rect_tab[k].width) &&
                                dy >= ty && dy < ty + sx24(rect_tab[k].height)) begin
                                found          = 1'b1;
                                res.hit        = 1'b1;
                                res.rect_index = k[IDX_OUT_W-1:0];
                            end
                        end
                    end
                end
            end
            REQ_CLEAR: index_clear();
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_req rq(input logic [1:0] op, input int x, input int y, input int w,
                                input int h, input bit sp, input bit fx, input bit lk,
                                input int px, input int py);
        t_req r;
        r.req_type     = op;
        r.rect_x       = x[23:0];
        r.rect_y       = y[23:0];
        r.rect_w       = w[23:0];
        r.rect_h       = h[23:0];
        r.spans_height = sp;
        r.is_fixed     = fx;
        r.is_link      = lk;
        r.point_x      = px[23:0];
        r.point_y      = py[23:0];
        return r;
    endfunction

    function automatic t_resp ans(input logic [1:0] st, input logic hit, input int idx);
        t_resp a;
        a.status     = st;
        a.hit        = hit;
        a.rect_index = idx[IDX_OUT_W-1:0];
        return a;
    endfunction

    function automatic t_dir_row drow(input t_req r, input bit given, input t_resp want);
        t_dir_row d;
        d.req   = r;
        d.given = given;
        d.want  = want;
        return d;
    endfunction

    // Random request: mostly inserts of plausible rectangles and queries aimed at
    // stored ones, with some raw noise on every field.
    function automatic t_req next_req();
        t_req        r;
        logic [159:0] raw;
        int          bhi, wl, hl;
        int unsigned sel, k;
        longint      w, h, dx, dy;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        r   = raw[$bits(t_req)-1:0];
        sel = $urandom_range(0, 99);
        bhi = eff_band_h();
        if (sel < 6) begin
            if (ph_clr_pct == 0 && r.req_type == REQ_CLEAR) r.req_type = REQ_UNKNOWN;
            return r;
        end
        if (sel < 6 + ph_clr_pct) begin
            r.req_type = REQ_CLEAR;
            return r;
        end
        if (sel < 6 + ph_clr_pct + ph_ins_pct) begin
            r.req_type = REQ_INSERT;
            w = $urandom_range(1, 300);
            h = $urandom_range(1, bhi * 3);
            case ($urandom_range(0, 19))
                0: w = -longint'($urandom_range(0, 5));
                1: h = -longint'($urandom_range(0, 5));
                default: ;
            endcase
            r.rect_x       = c24($urandom_range(0, 2000));
            r.rect_y       = c24(longint'($urandom_range(0, bhi * ph_span)) - bhi);
            r.rect_w       = c24(w);
            r.rect_h       = c24(h);
            r.spans_height = ($urandom_range(0, 99) < 85);
            r.is_fixed     = ($urandom_range(0, 99) < ph_fix_pct);
            r.is_link      = ($urandom_range(0, 3) != 0);
            return r;
        end
        r.req_type = REQ_QUERY;
        if (rect_total != 0 && $urandom_range(0, 4) != 0) begin
            k  = $urandom_range(0, rect_total - 1);
            w  = sx24(rect_tab[k].width);
            h  = sx24(rect_tab[k].height);
            wl = (w > 2000) ? 2000 : int'(w);
            hl = (h > 2000) ? 2000 : int'(h);
            dx = sx24(rect_tab[k].left) + ((w > 0) ? $urandom_range(0, wl - 1) : 0);
            dy = sx24(rect_tab[k].top) + ((h > 0) ? $urandom_range(0, hl - 1) : 0);
        end else begin
            dx = $urandom_range(0, 2500);
            dy = $urandom_range(0, bhi * ph_span);
        end
        r.point_x = c24(dx + cur_org_x);
        r.point_y = c24(dy + cur_org_y - longint'(cur_scroll));
        return r;
    endfunction

    function automatic int src_gap();
        int g;
        g = $urandom_range(0, 19);
        if (ph_steady || g < 8) return 0;
        if (g < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offers one request and holds it until the transfer; the caller lowers valid.
    task automatic issue(input t_req r, input bit given, input t_resp want);
        t_resp p;
        i_in_valid <= 1'b1;
        i_in       <= r;
        do @(posedge i_clk); while (!o_in_ready);
        p = index_apply(r);
        if (r.req_type == REQ_INSERT && p.status == ST_TABLE_FULL) full_seen++;
        pending_resp.push_back(given ? want : p);
        n_accepted++;
    endtask

    task automatic idle_in(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_apply(idx, d);
        if ($urandom_range(0, 1) == 1) begin
            i_cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int bh, input int ox, input int oy, input int sc,
                             input int n_items, input int ins, input int clr, input int fix,
                             input int span, input bit steady);
        logic [31:0] junk;
        int          n;
        // Registers change only once every outstanding result has come back.
        i_in_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        junk = $urandom;
        write_reg(CFG_BAND_HEIGHT, {junk[11:0], bh[11:0]});
        write_reg(CFG_ORIGIN_X, ox[23:0]);
        write_reg(CFG_ORIGIN_Y, oy[23:0]);
        write_reg(CFG_SCROLL, {junk[12], sc[22:0]});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        ph_ins_pct = ins;
        ph_clr_pct = clr;
        ph_fix_pct = fix;
        ph_span    = span;
        ph_steady  = steady;
        full_seen  = 0;
        for (n = 0; n < n_items && full_seen < 25; n++) begin
            issue(next_req(), 1'b0, '0);
            idle_in(src_gap());
        end
    endtask

    initial begin : stimulus
        t_dir_row dir_tab [$];
        int       i;
        cur_band_h = BH_RESET;
        cur_org_x  = 0;
        cur_org_y  = 0;
        cur_scroll = '0;
        index_clear();
        ph_steady  = 1'b0;

        dir_tab = '{
            drow(rq(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 15, 15), 1, ans(ST_OK, 0, 0)),
            drow(rq(REQ_INSERT, 10, 10, 20, 20, 1, 0, 1, 0, 0), 1, ans(ST_OK, 0, 0)),
            drow(rq(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 15, 15), 1, ans(ST_OK, 1, 0)),
            drow(rq(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 30, 30), 1, ans(ST_OK, 0, 0)),
            drow(rq(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 10, 10), 1, ans(ST_OK, 1, 0)),
            drow(rq(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, -1, 15), 1, ans(ST_OK, 0, 0)),
            drow(rq(REQ_INSERT, 0, 0, 100, 100, 1, 1, 1, 0, 0), 1, ans(ST_OK, 0, 1)),
            drow(rq(REQ_INSERT, 0, 0, 100, 100, 1, 0, 0, 0, 0), 1, ans(ST_OK, 0, 2)),
            drow(rq(REQ_INSERT, 0, 0, 0, 100, 1, 0, 1, 0, 0), 1, ans(ST_OK, 0, 3)),
            drow(rq(REQ_INSERT, 0, 0, 100, -5, 1, 0, 1, 0, 0), 1, ans(ST_OK, 0, 4)),
            drow(rq(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 50, 50), 0, '0),
            drow(rq(REQ_INSERT, 0, 100, 50, 200, 0, 0, 1, 0, 0), 0, '0),
            drow(rq(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 10, 150), 0, '0),
            drow(rq(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 10, 250), 0, '0),
            drow(rq(REQ_INSERT, 0, 5000, 10, 10, 1, 0, 1, 0, 0), 1, ans(ST_BAND_ERR, 0, 6)),
            drow(rq(REQ_INSERT, 0, -100, 10, 50, 1, 0, 1, 0, 0), 0, '0),
            drow(rq(REQ_INSERT, -8388608, 8388607, 8388607, 8388607, 1, 0, 1, 0, 0),
                 1, ans(ST_BAND_ERR, 0, 8)),
            drow(rq(REQ_INSERT, 8388607, -8388608, -8388608, -8388608, 0, 0, 0, 0, 0), 0, '0),
            drow(rq(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 8388607, 8388607), 1, ans(ST_OK, 0, 0)),
            drow(rq(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, -8388608, -8388608), 1, ans(ST_OK, 0, 0)),
            drow(rq(REQ_UNKNOWN, -1, -1, -1, -1, 1, 1, 1, -1, -1), 1, ans(ST_OK, 0, 0)),
            drow(rq(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0)),
            drow(rq(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 15, 15), 1, ans(ST_OK, 0, 0)),
            drow(rq(REQ_INSERT, 10, 10, 20, 20, 1, 0, 1, 0, 0), 1, ans(ST_OK, 0, 0))
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < dir_tab.size(); i++) begin
            issue(dir_tab[i].req, dir_tab[i].given, dir_tab[i].want);
            idle_in(src_gap());
        end

        run_phase(16, 0, 0, 0, 100, 45, 4, 10, 70, 1'b0);
        // Zero band height acts as one pixel; origins and scroll at their limits.
        run_phase(0, -8388608, 8388607, 8388607, 70, 50, 3, 10, 70, 1'b0);
        // Tall bands with rectangles packed near the top overflow the first band lists.
        run_phase(4095, 8388607, -8388608, 0, 90, 80, 0, 0, 2, 1'b1);
        // No clears: run the rectangle table up to full and beyond.
        run_phase($urandom_range(8, 200), int'($urandom_range(0, 6000)) - 3000,
                  int'($urandom_range(0, 6000)) - 3000, $urandom_range(0, 5000),
                  1300, 92, 0, 50, 70, 1'b0);
        run_phase(1, int'($urandom), int'($urandom), $urandom_range(0, 8388607),
                  100, 45, 5, 10, 70, 1'b0);

        i_in_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0 && pending_resp.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Output pacing, including one long hold-off that backs the block up.
    initial begin : sink_pace
        int hold;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!squeeze_done && n_accepted >= 60) begin
                squeeze_done = 1'b1;
                i_out_ready <= 1'b0;
                hold = 600;
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
            end else begin
                i_out_ready <= 1'b1;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 8);
            end
            repeat (hold) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : resp_check
        t_resp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_resp.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result transfer: status %0d hit %0d index %0d",
                             o_out.status, o_out.hit, o_out.rect_index);
            end else begin
                want = pending_resp.pop_front();
                if (o_out.status !== want.status || o_out.hit !== want.hit ||
                    o_out.rect_index !== want.rect_index) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("result mismatch: expected status %0d hit %0d index %0d, %s",
                                 want.status, want.hit, want.rect_index,
                                 $sformatf("got status %0d hit %0d index %0d",
                                           o_out.status, o_out.hit, o_out.rect_index));
                end
            end
        end
    end

    initial begin : watchdog
        #30000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
